FILE: rtl/rsx_pkg.sv
// Shared types and constants of the RISC subset execute unit.
`timescale 1ns / 1ps
`default_nettype none
package rsx_pkg;

    localparam int DATA_DEPTH_DEF = 65536;
    localparam int PROG_DEPTH     = 65536;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_ADDI = 4'd3,
        OP_LW   = 4'd4,
        OP_SW   = 4'd5,
        OP_BEQ  = 4'd6,
        OP_BNE  = 4'd7,
        OP_J    = 4'd8,
        OP_SLT  = 4'd9
    } t_op;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [4:0]         first_reg;
        logic [4:0]         second_reg;
        logic [4:0]         third_reg;
        logic signed [31:0] immediate;
        logic [15:0]        branch_target;
    } t_in_beat;

    typedef struct packed {
        logic [16:0]        next_pc;
        logic               halted;
        logic               reg_written;
        logic [4:0]         write_index;
        logic signed [31:0] write_value;
        logic               fault;
        logic [31:0]        retired_count;
    } t_out_beat;

endpackage
`default_nettype wire

FILE: rtl/rsx_regfile.sv
// Register file: two mirrored synchronous memories, valid bits and write forwarding.
`timescale 1ns / 1ps
`default_nettype none
module rsx_regfile (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic [4:0]  i_rd_a,
    input  wire logic [4:0]  i_rd_b,
    input  wire logic [4:0]  i_rd_c,
    output logic      [31:0] o_rd_a,
    output logic      [31:0] o_rd_b,
    output logic      [31:0] o_rd_c,
    input  wire logic        i_wr_en,
    input  wire logic [4:0]  i_wr_idx,
    input  wire logic [31:0] i_wr_data
);

    logic [31:0] r_mem_bc [32];
    logic [31:0] r_mem_a  [32];
    logic [31:0] r_valid;
    logic [31:0] r_dout_a;
    logic [31:0] r_dout_b;
    logic [31:0] r_dout_c;
    logic [4:0]  r_idx_a;
    logic [4:0]  r_idx_b;
    logic [4:0]  r_idx_c;
    logic        r_vld_a;
    logic        r_vld_b;
    logic        r_vld_c;
    logic        r_fw_vld;
    logic [4:0]  r_fw_idx;
    logic [31:0] r_fw_val;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_bc[i_wr_idx] <= i_wr_data;
            r_mem_a[i_wr_idx]  <= i_wr_data;
        end
        if (i_rd_en) begin
            r_dout_a <= r_mem_a[i_rd_a];
            r_dout_b <= r_mem_bc[i_rd_b];
            r_dout_c <= r_mem_bc[i_rd_c];
            r_idx_a  <= i_rd_a;
            r_idx_b  <= i_rd_b;
            r_idx_c  <= i_rd_c;
            r_vld_a  <= r_valid[i_rd_a];
            r_vld_b  <= r_valid[i_rd_b];
            r_vld_c  <= r_valid[i_rd_c];
        end
        if (i_wr_en) begin
            r_fw_idx <= i_wr_idx;
            r_fw_val <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_fw_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
                r_fw_vld          <= 1'b1;
            end else if (i_rd_en) begin
                r_fw_vld <= 1'b0;
            end
        end
    end

    // A write that lands at or after the read edge overrides the stale memory word.
    always_comb begin
        o_rd_a = (r_fw_vld && r_fw_idx == r_idx_a) ? r_fw_val : (r_vld_a ? r_dout_a : '0);
        o_rd_b = (r_fw_vld && r_fw_idx == r_idx_b) ? r_fw_val : (r_vld_b ? r_dout_b : '0);
        o_rd_c = (r_fw_vld && r_fw_idx == r_idx_c) ? r_fw_val : (r_vld_c ? r_dout_c : '0);
    end

endmodule
`default_nettype wire

FILE: rtl/rsx_dmem.sv
// Data memory: single-port synchronous word store with a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module rsx_dmem #(
    parameter int DATA_DEPTH = rsx_pkg::DATA_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [$clog2(DATA_DEPTH)-1:0] i_addr,
    input  wire logic                          i_wr_en,
    input  wire logic [31:0]                   i_wr_data,
    input  wire logic                          i_rd_en,
    output logic      [31:0]                   o_rd_data,
    output logic                               o_busy
);

    localparam int AW = $clog2(DATA_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DATA_DEPTH - 1);

    logic [31:0]   r_mem [DATA_DEPTH];
    logic [31:0]   r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule
`default_nettype wire

FILE: rtl/risc_subset_execute_unit.sv
// Top level of the RISC subset execute unit: execute stage, load stage and result register.
//
//   channel  direction  handshake                beat
//   in       input      i_in_valid / o_in_stall   t_in_beat, one decoded instruction
//   out      output     o_out_valid / i_out_stall t_out_beat, one result per instruction
//   cfg      input      i_cfg_valid / o_cfg_ready 16-bit last program address
//
// An instruction is read from the register file, then executed. A load adds a load stage
// for the data memory read, but the next instruction can be read while the load finishes,
// with the loaded word forwarded. After reset the data memory is cleared one word a cycle,
// with the input stalled. A stalled output holds the finished beat while the next
// instruction is read; execution waits only when the result register cannot be emptied
// or a load still waits in the load stage.
`timescale 1ns / 1ps
`default_nettype none
module risc_subset_execute_unit #(
    parameter int DATA_DEPTH = rsx_pkg::DATA_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rsx_pkg::t_in_beat i_in_beat,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output rsx_pkg::t_out_beat     o_out_beat,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [15:0]       i_cfg_data
);

    import rsx_pkg::*;

    localparam int AW = $clog2(DATA_DEPTH);
    localparam logic [32:0] DEPTH33   = 33'(DATA_DEPTH);
    localparam logic [16:0] PROG_LAST = 17'(PROG_DEPTH - 1);

    logic        accept;
    logic        dm_busy;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] vc;
    logic [31:0] dm_rdata;

    logic [15:0] r_last;
    logic [16:0] r_pc;
    logic [31:0] r_cnt;
    logic        r_stopped;
    logic        r_fault;

    logic        r_ex_vld;
    t_in_beat    r_ex;
    logic        r_m_vld;
    t_out_beat   r_m_res;
    logic        r_m_wr;
    logic [4:0]  r_m_idx;
    logic        r_out_vld;
    t_out_beat   r_out;

    logic        out_free;
    logic        ex_fire;
    logic        m_fire;
    logic [16:0] bound;
    logic [32:0] sum33;
    logic        in_range;

    t_out_beat   n_res;
    t_out_beat   m_res;
    logic        to_mem;
    logic        ex_rf_we;
    logic        dm_we;
    logic        dm_re;
    logic [16:0] n_pc;
    logic [31:0] n_cnt;
    logic        n_stop;
    logic        n_fault;

    logic        rf_we;
    logic [4:0]  rf_widx;
    logic [31:0] rf_wdata;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_ex_vld || dm_busy;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign ex_fire     = r_ex_vld && !r_m_vld && out_free;
    assign m_fire      = r_m_vld && out_free;

    assign bound    = ({1'b0, r_last} > PROG_LAST) ? PROG_LAST : {1'b0, r_last};
    assign sum33    = {r_ex.immediate[31], r_ex.immediate} + {vc[31], vc};
    assign in_range = !sum33[32] && (sum33 < DEPTH33);

    always_comb begin
        logic        wr;
        logic [31:0] wval;
        logic [16:0] npc;
        wr       = 1'b0;
        wval     = '0;
        npc      = r_pc;
        to_mem   = 1'b0;
        ex_rf_we = 1'b0;
        dm_we    = 1'b0;
        dm_re    = 1'b0;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_stop   = r_stopped || (r_pc > bound);
        n_fault  = r_fault;
        if (!n_stop) begin
            n_cnt = (r_cnt != '1) ? r_cnt + 32'd1 : r_cnt;
            npc   = r_pc + 17'd1;
            unique case (t_op'(r_ex.req_type))
                OP_ADD: begin
                    wr   = 1'b1;
                    wval = vb + vc;
                end
                OP_SUB: begin
                    wr   = 1'b1;
                    wval = vb - vc;
                end
                OP_MUL: begin
                    wr   = 1'b1;
                    wval = vb * vc;
                end
                OP_ADDI: begin
                    wr   = 1'b1;
                    wval = vb + r_ex.immediate;
                end
                OP_LW, OP_SW: begin
                    if (!in_range) begin
                        n_fault = 1'b1;
                        n_stop  = 1'b1;
                        npc     = r_pc;
                    end else if (t_op'(r_ex.req_type) == OP_LW) begin
                        to_mem = 1'b1;
                        dm_re  = 1'b1;
                    end else begin
                        dm_we = 1'b1;
                    end
                end
                OP_BEQ: begin
                    if (va == vb) begin
                        npc = {1'b0, r_ex.branch_target};
                    end
                end
                OP_BNE: begin
                    if (va != vb) begin
                        npc = {1'b0, r_ex.branch_target};
                    end
                end
                OP_J: begin
                    npc = {1'b0, r_ex.branch_target};
                end
                OP_SLT: begin
                    wr   = 1'b1;
                    wval = ($signed(vb) < $signed(vc)) ? 32'd1 : 32'd0;
                end
                default: begin
                end
            endcase
            if (wr && r_ex.first_reg != 5'd0) begin
                ex_rf_we = 1'b1;
            end else begin
                wval = '0;
            end
            n_pc = npc;
            if (npc > bound) begin
                n_stop = 1'b1;
            end
        end
        n_res.next_pc       = n_pc;
        n_res.halted        = n_stop;
        n_res.reg_written   = ex_rf_we;
        n_res.write_index   = ex_rf_we ? r_ex.first_reg : 5'd0;
        n_res.write_value   = wval;
        n_res.fault         = n_fault;
        n_res.retired_count = n_cnt;
    end

    always_comb begin
        m_res             = r_m_res;
        m_res.reg_written = r_m_wr;
        m_res.write_index = r_m_wr ? r_m_idx : 5'd0;
        m_res.write_value = r_m_wr ? dm_rdata : '0;
    end

    assign rf_we    = r_m_vld ? (m_fire && r_m_wr) : (ex_fire && ex_rf_we);
    assign rf_widx  = r_m_vld ? r_m_idx : r_ex.first_reg;
    assign rf_wdata = r_m_vld ? dm_rdata : n_res.write_value;

    rsx_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_a    (i_in_beat.first_reg),
        .i_rd_b    (i_in_beat.second_reg),
        .i_rd_c    (i_in_beat.third_reg),
        .o_rd_a    (va),
        .o_rd_b    (vb),
        .o_rd_c    (vc),
        .i_wr_en   (rf_we),
        .i_wr_idx  (rf_widx),
        .i_wr_data (rf_wdata)
    );

    rsx_dmem #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_addr    (sum33[AW-1:0]),
        .i_wr_en   (ex_fire && dm_we),
        .i_wr_data (va),
        .i_rd_en   (ex_fire && dm_re),
        .o_rd_data (dm_rdata),
        .o_busy    (dm_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_pc      <= '0;
            r_cnt     <= '0;
            r_stopped <= 1'b0;
            r_fault   <= 1'b0;
            r_ex_vld  <= 1'b0;
            r_m_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_last <= i_cfg_data;
            end
            if (ex_fire) begin
                r_pc      <= n_pc;
                r_cnt     <= n_cnt;
                r_stopped <= n_stop;
                r_fault   <= n_fault;
            end
            if (accept) begin
                r_ex_vld <= 1'b1;
            end else if (ex_fire) begin
                r_ex_vld <= 1'b0;
            end
            if (ex_fire && to_mem) begin
                r_m_vld <= 1'b1;
            end else if (m_fire) begin
                r_m_vld <= 1'b0;
            end
            if ((ex_fire && !to_mem) || m_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex <= i_in_beat;
        end
        if (ex_fire && to_mem) begin
            r_m_res <= n_res;
            r_m_wr  <= (r_ex.first_reg != 5'd0);
            r_m_idx <= r_ex.first_reg;
        end
        if (m_fire) begin
            r_out <= m_res;
        end else if (ex_fire && !to_mem) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench of the RISC subset execute unit with a built-in instruction predictor.
`timescale 1ns / 1ps
module tb_top;
    import rsx_pkg::*;

    localparam int          DATA_WORDS     = DATA_DEPTH_DEF;
    localparam logic [3:0]  OP_UNUSED_LO   = 4'd10;
    localparam logic [3:0]  OP_UNUSED_HI   = 4'd15;
    localparam int          DIRECTED_ROWS  = 24;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 200000;

    typedef enum int {HALT_FAULT, HALT_OVERRUN, HALT_BRANCH, HALT_LOWERED} t_halt_kind;

    typedef struct {
        t_in_beat  instr;
        bit        typed;
        t_out_beat result;
    } t_step_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b1;
    logic      cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_beat;
    logic      o_cfg_ready;

    logic [31:0] arch_regs [32] = '{default: '0};
    logic [31:0] arch_mem [int];
    logic [16:0] arch_pc      = '0;
    logic [31:0] arch_retired = '0;
    logic        arch_halted  = 1'b0;
    logic        arch_fault   = 1'b0;
    logic [15:0] arch_bound   = '0;

    t_out_beat   results_due[$];
    t_step_row   rows [DIRECTED_ROWS];
    int unsigned mismatches      = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int          burst_left      = 0;

    logic hold_off_req = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_left    = 0;
    int   stall_mode   = 0;
    int   stretch_left = 0;

    risc_subset_execute_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic t_in_beat make_instr(input logic [3:0] op, input logic [4:0] ra,
                                            input logic [4:0] rb, input logic [4:0] rc,
                                            input logic [31:0] imm, input logic [15:0] tgt);
        t_in_beat b;
        b.req_type      = op;
        b.first_reg     = ra;
        b.second_reg    = rb;
        b.third_reg     = rc;
        b.immediate     = imm;
        b.branch_target = tgt;
        return b;
    endfunction

    function automatic t_out_beat plain_result(input logic [16:0] pc, input logic [4:0] idx,
                                               input logic [31:0] val, input logic [31:0] count);
        t_out_beat r;
        r               = '0;
        r.next_pc       = pc;
        r.reg_written   = (idx != 5'd0);
        r.write_index   = idx;
        r.write_value   = val;
        r.retired_count = count;
        return r;
    endfunction

    function automatic t_out_beat execute_instr(input t_in_beat b);
        t_out_beat          r;
        logic [31:0]        va, vb, vc, wval;
        logic [16:0]        npc;
        logic signed [33:0] addr;
        logic               wr;
        wr   = 1'b0;
        wval = '0;
        if (!arch_halted && arch_pc > {1'b0, arch_bound}) begin
            arch_halted = 1'b1;
        end
        if (!arch_halted) begin
            va  = arch_regs[b.first_reg];
            vb  = arch_regs[b.second_reg];
            vc  = arch_regs[b.third_reg];
            npc = arch_pc + 17'd1;
            if (arch_retired != 32'hFFFF_FFFF) begin
                arch_retired++;
            end
            case (b.req_type)
                OP_ADD: begin
                    wr = 1'b1;
                    wval = vb + vc;
                end
                OP_SUB: begin
                    wr = 1'b1;
                    wval = vb - vc;
                end
                OP_MUL: begin
                    wr = 1'b1;
                    wval = vb * vc;
                end
                OP_ADDI: begin
                    wr = 1'b1;
                    wval = vb + b.immediate;
                end
                OP_SLT: begin
                    wr = 1'b1;
                    wval = ($signed(vb) < $signed(vc)) ? 32'd1 : 32'd0;
                end
                OP_LW, OP_SW: begin
                    addr = $signed(b.immediate) + $signed(vc);
                    if (addr < 0 || addr >= DATA_WORDS) begin
                        arch_fault  = 1'b1;
                        arch_halted = 1'b1;
                        npc         = arch_pc;
                    end else if (b.req_type == OP_LW) begin
                        wr   = 1'b1;
                        wval = arch_mem.exists(int'(addr)) ? arch_mem[int'(addr)] : '0;
                    end else begin
                        arch_mem[int'(addr)] = va;
                    end
                end
                OP_BEQ: begin
                    if (va == vb) npc = {1'b0, b.branch_target};
                end
                OP_BNE: begin
                    if (va != vb) npc = {1'b0, b.branch_target};
                end
                OP_J: begin
                    npc = {1'b0, b.branch_target};
                end
                default: begin
                end
            endcase
            if (wr && b.first_reg != 5'd0) begin
                arch_regs[b.first_reg] = wval;
            end else begin
                wr   = 1'b0;
                wval = '0;
            end
            arch_pc = npc;
            if (!arch_halted && arch_pc > {1'b0, arch_bound}) begin
                arch_halted = 1'b1;
            end
        end
        r.next_pc       = arch_pc;
        r.halted        = arch_halted;
        r.reg_written   = wr;
        r.write_index   = wr ? b.first_reg : 5'd0;
        r.write_value   = wval;
        r.fault         = arch_fault;
        r.retired_count = arch_retired;
        return r;
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] pick_imm();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return $urandom;
        if (roll < 8) return 32'($urandom_range(0, 32)) - 32'd16;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_target();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 3) return arch_bound;
        if (roll < 6) return 16'd0;
        return 16'($urandom_range(0, arch_bound));
    endfunction

    function automatic t_in_beat raw_instr();
        return make_instr(4'($urandom_range(0, 15)), 5'($urandom), 5'($urandom), 5'($urandom),
                          $urandom, 16'($urandom));
    endfunction

    function automatic t_in_beat pick_instr();
        t_in_beat    b;
        int unsigned roll, addr;
        longint      off;
        b = make_instr(OP_ADD, pick_reg(), pick_reg(), pick_reg(), pick_imm(), 16'($urandom));
        if (arch_pc == {1'b0, arch_bound}) begin
            if ($urandom_range(0, 1) == 0) begin
                b.req_type = OP_J;
            end else begin
                b.req_type   = OP_BEQ;
                b.second_reg = b.first_reg;
            end
            b.branch_target = pick_target();
            return b;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)       b.req_type = OP_ADD;
        else if (roll < 16) b.req_type = OP_SUB;
        else if (roll < 24) b.req_type = OP_MUL;
        else if (roll < 34) b.req_type = OP_ADDI;
        else if (roll < 42) b.req_type = OP_SLT;
        else if (roll < 57) b.req_type = OP_LW;
        else if (roll < 70) b.req_type = OP_SW;
        else if (roll < 80) b.req_type = OP_BEQ;
        else if (roll < 88) b.req_type = OP_BNE;
        else if (roll < 93) b.req_type = OP_J;
        else                b.req_type = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (b.req_type == OP_LW || b.req_type == OP_SW) begin
            roll = $urandom_range(0, 9);
            if (roll < 5)      addr = $urandom_range(0, 31);
            else if (roll < 7) addr = $urandom_range(DATA_WORDS - 32, DATA_WORDS - 1);
            else               addr = $urandom_range(0, DATA_WORDS - 1);
            off = longint'(addr) - longint'($signed(arch_regs[b.third_reg]));
            if (off != longint'($signed(off[31:0]))) begin
                b.third_reg = 5'd0;
                off         = longint'(addr);
            end
            b.immediate = off[31:0];
        end
        if (b.req_type == OP_BEQ || b.req_type == OP_BNE || b.req_type == OP_J) begin
            b.branch_target = pick_target();
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s is %0h, expected %0h", $time, results_checked, what,
                 got, want);
        mismatches++;
    endtask

    task automatic offer(input t_in_beat b, input bit typed, input t_out_beat typed_result);
        t_out_beat predicted;
        t_out_beat due;
        in_beat  <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (o_in_stall);
        predicted = execute_instr(b);
        due = typed ? typed_result : predicted;
        results_due = {results_due, due};
        items_sent++;
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 23);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = $urandom_range(0, 3);
            6, 7, 8: gap = $urandom_range(4, 12);
            default: gap = $urandom_range(20, 60);
        endcase
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bound(input logic [15:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        arch_bound = value;
    endtask

    task automatic run_random(input int count, input bit steady);
        for (int n = 0; n < count; n++) begin
            if (!steady) pace();
            offer(pick_instr(), 1'b0, '0);
        end
    endtask

    task automatic close_phase();
        pace();
        offer(make_instr(OP_J, 5'd0, 5'd0, 5'd0, 32'd0, 16'd0), 1'b0, '0);
        drain();
    endtask

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_off_req && !hold_taken) begin
            out_stall  <= 1'b1;
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
        end else begin
            if (stretch_left == 0) begin
                stall_mode   <= $urandom_range(0, 2);
                stretch_left <= $urandom_range(5, 60);
            end else begin
                stretch_left <= stretch_left - 1;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge clk) begin : check_results
        t_out_beat want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected beat, next_pc", 32'(o_out_beat.next_pc), '0);
            end else begin
                want = results_due.pop_front();
                if (o_out_beat.next_pc != want.next_pc)
                    report_mismatch("next_pc", 32'(o_out_beat.next_pc), 32'(want.next_pc));
                if (o_out_beat.halted != want.halted)
                    report_mismatch("halted", 32'(o_out_beat.halted), 32'(want.halted));
                if (o_out_beat.reg_written != want.reg_written)
                    report_mismatch("reg_written", 32'(o_out_beat.reg_written),
                                    32'(want.reg_written));
                if (o_out_beat.write_index != want.write_index)
                    report_mismatch("write_index", 32'(o_out_beat.write_index),
                                    32'(want.write_index));
                if (o_out_beat.write_value != want.write_value)
                    report_mismatch("write_value", o_out_beat.write_value, want.write_value);
                if (o_out_beat.fault != want.fault)
                    report_mismatch("fault", 32'(o_out_beat.fault), 32'(want.fault));
                if (o_out_beat.retired_count != want.retired_count)
                    report_mismatch("retired_count", o_out_beat.retired_count,
                                    want.retired_count);
            end
            results_checked++;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                    || (cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("No beat moved for %0d cycles with %0d results outstanding.", WATCHDOG_LIMIT,
                 results_due.size());
        $display("risc_subset_execute_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        t_halt_kind  halt_kind;
        int unsigned target;
        logic [15:0] small_bound;

        rows = '{
            '{make_instr(OP_ADDI, 1, 0, 0, 32'h7FFF_FFFF, 0), 1'b1,
              plain_result(1, 1, 32'h7FFF_FFFF, 1)},
            '{make_instr(OP_ADDI, 2, 0, 0, 32'h8000_0000, 16'hFFFF), 1'b1,
              plain_result(2, 2, 32'h8000_0000, 2)},
            '{make_instr(OP_ADD, 3, 1, 1, 0, 0), 1'b1, plain_result(3, 3, 32'hFFFF_FFFE, 3)},
            '{make_instr(OP_SUB, 4, 2, 1, 0, 0), 1'b1, plain_result(4, 4, 32'd1, 4)},
            '{make_instr(OP_MUL, 5, 1, 1, 0, 0), 1'b0, '0},
            '{make_instr(OP_MUL, 6, 2, 3, 0, 0), 1'b0, '0},
            '{make_instr(OP_SLT, 7, 2, 1, 0, 0), 1'b1, plain_result(7, 7, 32'd1, 7)},
            '{make_instr(OP_SLT, 8, 1, 2, 0, 0), 1'b1, plain_result(8, 8, 32'd0, 8)},
            '{make_instr(OP_ADDI, 0, 1, 0, 32'd5, 0), 1'b1, plain_result(9, 0, 0, 9)},
            '{make_instr(OP_SW, 1, 0, 0, 32'h0000_FFFF, 0), 1'b1, plain_result(10, 0, 0, 10)},
            '{make_instr(OP_LW, 9, 0, 0, 32'h0000_FFFF, 0), 1'b1,
              plain_result(11, 9, 32'h7FFF_FFFF, 11)},
            '{make_instr(OP_ADD, 10, 9, 9, 0, 0), 1'b0, '0},
            '{make_instr(OP_LW, 11, 0, 1, 32'h8000_0001, 0), 1'b1, plain_result(13, 11, 0, 13)},
            '{make_instr(OP_SW, 3, 0, 4, 32'd5, 0), 1'b0, '0},
            '{make_instr(OP_LW, 12, 0, 4, 32'd5, 0), 1'b0, '0},
            '{make_instr(OP_BEQ, 1, 1, 0, 0, 16'd100), 1'b1, plain_result(100, 0, 0, 16)},
            '{make_instr(OP_BNE, 1, 1, 0, 0, 16'd7), 1'b1, plain_result(101, 0, 0, 17)},
            '{make_instr(OP_BNE, 1, 2, 0, 0, 16'hFFFF), 1'b1, plain_result(65535, 0, 0, 18)},
            '{make_instr(OP_J, 0, 0, 0, 0, 16'hFFFF), 1'b1, plain_result(65535, 0, 0, 19)},
            '{make_instr(OP_J, 0, 0, 0, 0, 16'd0), 1'b1, plain_result(0, 0, 0, 20)},
            '{make_instr(OP_UNUSED_HI, 31, 31, 31, 32'hFFFF_FFFF, 0), 1'b1,
              plain_result(1, 0, 0, 21)},
            '{make_instr(OP_UNUSED_LO, 0, 0, 0, 0, 0), 1'b1, plain_result(2, 0, 0, 22)},
            '{make_instr(OP_BEQ, 0, 11, 0, 0, 16'h5A5A), 1'b1, plain_result(16'h5A5A, 0, 0, 23)},
            '{make_instr(OP_J, 0, 0, 0, 0, 16'd0), 1'b1, plain_result(0, 0, 0, 24)}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_bound(16'hFFFF);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            pace();
            offer(rows[i].instr, rows[i].typed, rows[i].result);
        end
        drain();

        run_random(110, 1'b0);
        close_phase();

        write_bound(16'd0);
        run_random(15, 1'b0);
        close_phase();

        small_bound = 16'($urandom_range(1, 48));
        write_bound(small_bound);
        run_random(100, 1'b0);
        close_phase();

        // The sink holds off for a long stretch while instructions keep coming.
        write_bound(16'hFFFF);
        hold_off_req <= 1'b1;
        run_random(70, 1'b1);
        run_random(60, 1'b0);
        close_phase();

        halt_kind = t_halt_kind'($urandom_range(0, 3));
        case (halt_kind)
            HALT_FAULT: begin
                offer(make_instr(($urandom_range(0, 1) == 0) ? OP_LW : OP_SW, pick_reg(),
                                 pick_reg(), 5'd0,
                                 ($urandom_range(0, 1) == 0) ? ($urandom | 32'h8000_0000)
                                     : $urandom_range(DATA_WORDS, 32'h7FFF_FFFF),
                                 16'($urandom)), 1'b0, '0);
            end
            HALT_OVERRUN: begin
                offer(make_instr(OP_J, 0, 0, 0, 0, 16'hFFFF), 1'b0, '0);
                offer(make_instr(OP_ADDI, pick_reg(), pick_reg(), 0, pick_imm(), 0), 1'b0, '0);
            end
            HALT_BRANCH: begin
                write_bound(16'($urandom_range(0, 1000)));
                target = $urandom_range(arch_bound + 1, 65535);
                offer(make_instr(OP_J, 0, 0, 0, 0, 16'(target)), 1'b0, '0);
            end
            default: begin
                target = $urandom_range(200, 65535);
                offer(make_instr(OP_J, 0, 0, 0, 0, 16'(target)), 1'b0, '0);
                drain();
                write_bound(16'($urandom_range(0, target - 1)));
                offer(raw_instr(), 1'b0, '0);
            end
        endcase
        repeat (8) begin
            pace();
            offer(raw_instr(), 1'b0, '0);
        end
        drain();
        write_bound(16'hFFFF);
        repeat (3) offer(raw_instr(), 1'b0, '0);
        drain();

        $display("Checked %0d results of %0d instructions over bounds 0, %0d and 65535,",
                 results_checked, items_sent, small_bound);
        $display("with a %0d-cycle sink hold-off; the run ended in a %s halt.", HOLD_CYCLES,
                 halt_kind.name());
        if (mismatches == 0) begin
            $display("risc_subset_execute_unit verification clean");
        end else begin
            $display("risc_subset_execute_unit verification failed");
        end
        $finish;
    end

endmodule
